>>> rtl/ptc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_pkg
// shared types, constants and helpers for the pressure/temperature compensation
// ----------------------------------------------------------------------------
package ptc_pkg;

  localparam int MulDigit   = 4;
  localparam int MulSteps   = 64 / MulDigit;
  localparam int DivSteps   = 64;
  localparam logic [63:0] TempOffset  = 64'd128000;
  localparam logic [63:0] RawFull     = 64'd1048576;
  localparam logic [63:0] PresScale   = 64'd3125;
  localparam logic [63:0] DivBias     = 64'h0000_8000_0000_0000;
  localparam logic [31:0] TempRound   = 32'd128;

  localparam logic [1:0] RegTempCal  = 2'd0;
  localparam logic [1:0] RegPresCalA = 2'd1;
  localparam logic [1:0] RegPresCalB = 2'd2;
  localparam logic [1:0] RegPresCalC = 2'd3;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_T_PREP,
    ST_T_MUL1,
    ST_T_MUL2,
    ST_T_MUL3,
    ST_T_FIN,
    ST_P_PREP,
    ST_P_AA,
    ST_P_B6,
    ST_P_B5,
    ST_P_B4,
    ST_P_X3,
    ST_P_X2,
    ST_P_X47,
    ST_P_X1,
    ST_P_NUM,
    ST_P_N3125,
    ST_P_DIV,
    ST_P_Q9,
    ST_P_QQ,
    ST_P_P8,
    ST_P_SUM,
    ST_P_FIN,
    ST_OUT
  } ptc_state_t;

  typedef struct packed {
    logic start;
    logic [63:0] opa;
    logic [63:0] opb;
  } ptc_req_t;

  function automatic logic [63:0] sx16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic [63:0] sx32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic logic [31:0] asr32(input logic [31:0] x, input logic [5:0] n);
    return $signed(x) >>> n;
  endfunction

  function automatic logic [63:0] asr64(input logic [63:0] x, input logic [5:0] n);
    return $signed(x) >>> n;
  endfunction

endpackage

>>> rtl/ptc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_if
// valid/ready channels for raw samples and compensated results
// ----------------------------------------------------------------------------
interface ptc_sample_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [19:0] raw_reading;
  modport source (output valid, mode, raw_reading, input ready);
  modport sink (input valid, mode, raw_reading, output ready);
endinterface

interface ptc_result_if;
  logic        valid;
  logic        ready;
  logic        measured_kind;
  logic [31:0] temperature_centi;
  logic [31:0] pressure_q24_8;
  logic        divisor_zero;
  modport source (output valid, measured_kind, temperature_centi, pressure_q24_8,
                  divisor_zero, input ready);
  modport sink (input valid, measured_kind, temperature_centi, pressure_q24_8,
                divisor_zero, output ready);
endinterface

>>> rtl/pressure_temperature_compensation_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pressure_temperature_compensation_core
// integer temperature and 64-bit pressure compensation of raw sensor samples
// ----------------------------------------------------------------------------
// usage:
//   sample channel takes one word: mode (0 temperature, 1 pressure) and a
//   20-bit raw reading. result channel returns one word per sample.
//   calibration words are written over the apb port at 8*i while idle.
// timing:
//   one sample at a time. products come from a shared multiplier taking one
//   4-bit digit per cycle, the quotient from a divider taking one bit per
//   cycle. temperature uses only the multiplier; pressure also uses the
//   divider, and skips the divide and the products after it when the
//   divisor is zero. the next sample can be taken in the cycle after the
//   result register is loaded.
// reset:
//   clears calibration, fine temperature and the result valid flag.
// stall:
//   a held result keeps the block from finishing the next sample; a new
//   sample is taken only when the sequencer is idle.
// ----------------------------------------------------------------------------
module pressure_temperature_compensation_core
  import ptc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  ptc_sample_if.sink   sample,
  ptc_result_if.source result,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  ptc_state_t state, state_next;

  logic [47:0] cal_t;
  logic [63:0] cal_a;
  logic [63:0] cal_b;
  logic [15:0] cal_c;
  logic [31:0] fine;

  logic [19:0] raw_q;
  logic [63:0] a_r, b_r, x_r, p_r;
  logic        launched;

  logic        pend_kind;
  logic [31:0] pend_temp;
  logic [31:0] pend_pres;
  logic        pend_dz;

  ptc_req_t    mul_req, div_req;
  logic        mul_done, div_done;
  logic [63:0] prod, quot;
  logic        mul_state;
  logic        div_neg;
  logic [63:0] q13;
  logic [31:0] t1, f5;

  assign pready = 1'b1;
  assign t1     = {16'b0, cal_t[15:0]};
  assign q13    = asr64(p_r, 6'd13);
  assign f5     = (fine << 2) + fine + TempRound;
  assign div_neg = a_r[63] ^ p_r[63];

  // apb
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_t <= '0;
      cal_a <= '0;
      cal_b <= '0;
      cal_c <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:3])
        RegTempCal:  cal_t <= pwdata[47:0];
        RegPresCalA: cal_a <= pwdata;
        RegPresCalB: cal_b <= pwdata;
        RegPresCalC: cal_c <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      RegTempCal:  prdata = {16'b0, cal_t};
      RegPresCalA: prdata = cal_a;
      RegPresCalB: prdata = cal_b;
      RegPresCalC: prdata = {48'b0, cal_c};
      default:     prdata = '0;
    endcase
  end

  // multiplier operands and divider request
  always_comb begin
    mul_state   = 1'b1;
    mul_req.opa = a_r;
    mul_req.opb = a_r;
    unique case (state)
      ST_T_MUL1:  mul_req.opb = sx16(cal_t[31:16]);
      ST_T_MUL2:  begin mul_req.opa = b_r; mul_req.opb = b_r; end
      ST_T_MUL3:  begin mul_req.opa = b_r; mul_req.opb = sx16(cal_t[47:32]); end
      ST_P_AA:    ;
      ST_P_B6:    begin mul_req.opa = p_r; mul_req.opb = sx16(cal_b[31:16]); end
      ST_P_B5:    mul_req.opb = sx16(cal_b[15:0]);
      ST_P_X3:    begin mul_req.opa = p_r; mul_req.opb = sx16(cal_a[47:32]); end
      ST_P_X2:    mul_req.opb = sx16(cal_a[31:16]);
      ST_P_X1:    begin mul_req.opa = x_r; mul_req.opb = {48'b0, cal_a[15:0]}; end
      ST_P_N3125: begin mul_req.opa = p_r; mul_req.opb = PresScale; end
      ST_P_Q9:    begin mul_req.opa = sx16(cal_c); mul_req.opb = q13; end
      ST_P_QQ:    begin mul_req.opa = x_r; mul_req.opb = q13; end
      ST_P_P8:    begin mul_req.opa = sx16(cal_b[63:48]); mul_req.opb = p_r; end
      default:    mul_state = 1'b0;
    endcase
    mul_req.start = mul_state && !launched;
    div_req.start = (state == ST_P_DIV) && !launched;
    div_req.opa   = p_r[63] ? 64'd0 - p_r : p_r;
    div_req.opb   = a_r[63] ? 64'd0 - a_r : a_r;
  end

  ptc_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .req     (mul_req),
    .done    (mul_done),
    .product (prod)
  );

  ptc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (quot)
  );

  // sequencer
  always_comb begin
    state_next   = state;
    sample.ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        sample.ready = 1'b1;
        if (sample.valid) state_next = sample.mode ? ST_P_PREP : ST_T_PREP;
      end
      ST_T_PREP:  state_next = ST_T_MUL1;
      ST_T_MUL1:  if (mul_done) state_next = ST_T_MUL2;
      ST_T_MUL2:  if (mul_done) state_next = ST_T_MUL3;
      ST_T_MUL3:  if (mul_done) state_next = ST_T_FIN;
      ST_T_FIN:   state_next = ST_OUT;
      ST_P_PREP:  state_next = ST_P_AA;
      ST_P_AA:    if (mul_done) state_next = ST_P_B6;
      ST_P_B6:    if (mul_done) state_next = ST_P_B5;
      ST_P_B5:    if (mul_done) state_next = ST_P_B4;
      ST_P_B4:    state_next = ST_P_X3;
      ST_P_X3:    if (mul_done) state_next = ST_P_X2;
      ST_P_X2:    if (mul_done) state_next = ST_P_X47;
      ST_P_X47:   state_next = ST_P_X1;
      ST_P_X1:    if (mul_done) state_next = ST_P_NUM;
      ST_P_NUM:   state_next = (a_r == '0) ? ST_OUT : ST_P_N3125;
      ST_P_N3125: if (mul_done) state_next = ST_P_DIV;
      ST_P_DIV:   if (div_done) state_next = ST_P_Q9;
      ST_P_Q9:    if (mul_done) state_next = ST_P_QQ;
      ST_P_QQ:    if (mul_done) state_next = ST_P_P8;
      ST_P_P8:    if (mul_done) state_next = ST_P_SUM;
      ST_P_SUM:   state_next = ST_P_FIN;
      ST_P_FIN:   state_next = ST_OUT;
      ST_OUT:     if (!result.valid || result.ready) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      launched     <= 1'b0;
      fine         <= '0;
      result.valid <= 1'b0;
    end else begin
      if (mul_req.start || div_req.start) launched <= 1'b1;
      if (mul_done || div_done) launched <= 1'b0;
      if (state == ST_OUT && (!result.valid || result.ready)) begin
        result.valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          raw_q     <= sample.raw_reading;
          pend_kind <= sample.mode;
          pend_temp <= '0;
          pend_pres <= '0;
          pend_dz   <= 1'b0;
        end
        ST_T_PREP: begin
          a_r[31:0] <= {12'b0, raw_q >> 3} - (t1 << 1);
          b_r[31:0] <= {12'b0, raw_q >> 4} - t1;
        end
        ST_T_MUL1:  if (mul_done) x_r[31:0] <= asr32(prod[31:0], 6'd11);
        ST_T_MUL2:  if (mul_done) b_r[31:0] <= asr32(prod[31:0], 6'd12);
        ST_T_MUL3:  if (mul_done) fine <= x_r[31:0] + asr32(prod[31:0], 6'd14);
        ST_T_FIN:   pend_temp <= asr32(f5, 6'd8);
        ST_P_PREP:  a_r <= sx32(fine) - TempOffset;
        ST_P_AA:    if (mul_done) p_r <= prod;
        ST_P_B6:    if (mul_done) b_r <= prod;
        ST_P_B5:    if (mul_done) b_r <= b_r + (prod << 17);
        ST_P_B4:    b_r <= b_r + (sx16(cal_a[63:48]) << 35);
        ST_P_X3:    if (mul_done) x_r <= asr64(prod, 6'd8);
        ST_P_X2:    if (mul_done) x_r <= x_r + (prod << 12);
        ST_P_X47:   x_r <= x_r + DivBias;
        ST_P_X1:    if (mul_done) a_r <= asr64(prod, 6'd33);
        ST_P_NUM: begin
          if (a_r == '0) pend_dz <= 1'b1;
          p_r <= ((RawFull - {44'b0, raw_q}) << 31) - b_r;
        end
        ST_P_N3125: if (mul_done) p_r <= prod;
        ST_P_DIV:   if (div_done) p_r <= div_neg ? 64'd0 - quot : quot;
        ST_P_Q9:    if (mul_done) x_r <= prod;
        ST_P_QQ:    if (mul_done) x_r <= asr64(prod, 6'd25);
        ST_P_P8:    if (mul_done) b_r <= asr64(prod, 6'd19);
        ST_P_SUM:   x_r <= p_r + x_r + b_r;
        ST_P_FIN: begin
          pend_pres <= 32'(asr64(x_r, 6'd8) + (sx16(cal_b[47:32]) << 4));
        end
        ST_OUT: begin
          if (!result.valid || result.ready) begin
            result.measured_kind     <= pend_kind;
            result.temperature_centi <= pend_temp;
            result.pressure_q24_8    <= pend_pres;
            result.divisor_zero      <= pend_dz;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/ptc_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_mul
// digit-serial 64x64 multiplier, low 64 product bits, one 4-bit digit a cycle
// ----------------------------------------------------------------------------
module ptc_mul
  import ptc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  ptc_req_t    req,
  output logic        done,
  output logic [63:0] product
);

  logic [63:0] mc;
  logic [63:0] mr;
  logic [63:0] acc;
  logic [$clog2(MulSteps)-1:0] cnt;
  logic        busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        mc   <= req.opa;
        mr   <= req.opb;
        acc  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        acc <= acc + 64'(mc * mr[MulDigit-1:0]);
        mc  <= mc << MulDigit;
        mr  <= mr >> MulDigit;
        cnt <= cnt + 1'b1;
        if (cnt == $clog2(MulSteps)'(MulSteps - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign product = acc;

endmodule

>>> rtl/ptc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_div
// bit-serial restoring 64-bit unsigned divider, one quotient bit a cycle
// ----------------------------------------------------------------------------
module ptc_div
  import ptc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  ptc_req_t    req,
  output logic        done,
  output logic [63:0] quotient
);

  logic [63:0] rem;
  logic [63:0] quo;
  logic [63:0] dsr;
  logic [$clog2(DivSteps)-1:0] cnt;
  logic        busy;
  logic [64:0] trial;
  logic [64:0] diff;

  assign trial = {rem, quo[63]};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem  <= '0;
        quo  <= req.opa;
        dsr  <= req.opb;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (!diff[64]) begin
          rem <= diff[63:0];
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= trial[63:0];
          quo <= {quo[62:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == $clog2(DivSteps)'(DivSteps - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

>>> rtl/ptc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_checker
// port-level checks on the result channel of the compensation core
// ----------------------------------------------------------------------------
module ptc_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_kind,
  input logic [31:0] out_temp,
  input logic [31:0] out_pres,
  input logic        out_dz
);

  a_reset_clear: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_pres) && $stable(out_temp))
    else $error("stalled result changed");

  a_temp_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_kind |-> out_pres == 32'd0 && !out_dz)
    else $error("temperature word carries pressure fields");

  a_pres_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind |-> out_temp == 32'd0)
    else $error("pressure word carries temperature");

  a_zero_div: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_dz |-> out_pres == 32'd0)
    else $error("zero divisor with nonzero pressure");

endmodule

bind pressure_temperature_compensation_core ptc_checker u_ptc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_kind  (result.measured_kind),
  .out_temp  (result.temperature_centi),
  .out_pres  (result.pressure_q24_8),
  .out_dz    (result.divisor_zero)
);

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the pressure/temperature compensation core: apb
// calibration phases, a directed table, then random words partly under idling,
// each result compared with table values or an in-bench compensation predictor
// ----------------------------------------------------------------------------
module tb;
  import ptc_pkg::*;

  typedef struct {
    logic        mode;
    logic [19:0] raw;
    logic        known;
    logic [31:0] temp;
    logic [31:0] pres;
    logic        dz;
  } row_t;

  typedef struct {
    logic        kind;
    logic [31:0] temp;
    logic [31:0] pres;
    logic        dz;
  } comp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  ptc_sample_if sample ();
  ptc_result_if result ();

  pressure_temperature_compensation_core dut (
    .clk(clk), .rst(rst), .sample(sample.sink), .result(result.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  logic [47:0] cal_t;
  logic [63:0] cal_a, cal_b;
  logic [15:0] cal_c;
  logic [31:0] t_fine;
  comp_t results_due[$];
  int errors = 0;
  int send_idle = 0, recv_idle = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #200ms;
    $display("FAIL");
    $finish;
  end

  function automatic comp_t compensate(logic mode, logic [19:0] raw);
    comp_t r;
    logic [31:0] t1, t2, t3, d1, v1, d2, v2;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, a, b, p, q;
    r = '{mode, 32'd0, 32'd0, 1'b0};
    if (!mode) begin
      t1 = {16'd0, cal_t[15:0]};
      t2 = {{16{cal_t[31]}}, cal_t[31:16]};
      t3 = {{16{cal_t[47]}}, cal_t[47:32]};
      d1 = (raw >> 3) - (t1 << 1);
      v1 = $signed(d1 * t2) >>> 11;
      d2 = (raw >> 4) - t1;
      v2 = $signed(d2 * d2) >>> 12;
      v2 = $signed(v2 * t3) >>> 14;
      t_fine = v1 + v2;
      r.temp = $signed(t_fine * 32'd5 + 32'd128) >>> 8;
    end else begin
      p1 = {48'd0, cal_a[15:0]};
      p2 = {{48{cal_a[31]}}, cal_a[31:16]};
      p3 = {{48{cal_a[47]}}, cal_a[47:32]};
      p4 = {{48{cal_a[63]}}, cal_a[63:48]};
      p5 = {{48{cal_b[15]}}, cal_b[15:0]};
      p6 = {{48{cal_b[31]}}, cal_b[31:16]};
      p7 = {{48{cal_b[47]}}, cal_b[47:32]};
      p8 = {{48{cal_b[63]}}, cal_b[63:48]};
      p9 = {{48{cal_c[15]}}, cal_c};
      a = {{32{t_fine[31]}}, t_fine} - 64'd128000;
      b = a * a * p6;
      b = b + ((a * p5) << 17);
      b = b + (p4 << 35);
      q = $signed(a * a * p3) >>> 8;
      a = q + ((a * p2) << 12);
      a = $signed(((64'd1 << 47) + a) * p1) >>> 33;
      if (a == 0) begin
        r.dz = 1'b1;
      end else begin
        p = 64'd1048576 - {44'd0, raw};
        p = ((p << 31) - b) * 64'd3125;
        if (a == '1 && p == 64'h8000_0000_0000_0000) p = p;
        else p = $signed(p) / $signed(a);
        q = $signed(p) >>> 13;
        a = $signed(p9 * q * q) >>> 25;
        b = $signed(p8 * p) >>> 19;
        p = $signed(p + a + b) >>> 8;
        p = p + (p7 << 4);
        r.pres = p[31:0];
      end
    end
    return r;
  endfunction

  task automatic write_cal(logic [1:0] idx, logic [63:0] v);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 3'b000}; pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      RegTempCal:  cal_t = v[47:0];
      RegPresCalA: cal_a = v;
      RegPresCalB: cal_b = v;
      default:     cal_c = v[15:0];
    endcase
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // valid stays high after the word is taken until the next idle or drain
  task automatic send_word(logic mode, logic [19:0] raw);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      sample.valid <= 1'b0;
      @(negedge clk);
    end
    sample.valid <= 1'b1;
    sample.mode <= mode;
    sample.raw_reading <= raw;
    do @(posedge clk); while (!sample.ready);
    results_due.push_back(compensate(mode, raw));
    @(negedge clk);
  endtask

  task automatic drain();
    sample.valid <= 1'b0;
    while (results_due.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  always @(negedge clk) begin
    result.ready <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);
  end

  always @(posedge clk) begin
    comp_t e;
    if (!rst && result.valid && result.ready) begin
      if (results_due.size() == 0) begin
        $error("result word with none due");
        errors++;
      end else begin
        e = results_due.pop_front();
        if (result.measured_kind !== e.kind) begin
          $error("measured_kind exp %0d got %0d", e.kind, result.measured_kind);
          errors++;
        end
        if (result.temperature_centi !== e.temp) begin
          $error("temperature_centi exp %0h got %0h", e.temp, result.temperature_centi);
          errors++;
        end
        if (result.pressure_q24_8 !== e.pres) begin
          $error("pressure_q24_8 exp %0h got %0h", e.pres, result.pressure_q24_8);
          errors++;
        end
        if (result.divisor_zero !== e.dz) begin
          $error("divisor_zero exp %0d got %0d", e.dz, result.divisor_zero);
          errors++;
        end
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // typical sensor calibration with random nudges
  task automatic set_typical();
    write_cal(RegTempCal, {16'($signed(-16'd1000) + $urandom_range(2000)),
                           16'(26000 + $urandom_range(2000)),
                           16'(27000 + $urandom_range(2000))});
    write_cal(RegPresCalA, {16'(2800 + $urandom_range(400)),
                            16'(16'sd0 - 16'sd4800 + $urandom_range(800)),
                            16'(16'sd0 - 16'sd11000 + $urandom_range(2000)),
                            16'(35000 + $urandom_range(2000))});
    write_cal(RegPresCalB, {16'(16'sd0 - 16'sd7500 + $urandom_range(1000)),
                            16'(15000 + $urandom_range(1000)),
                            16'(16'sd0 - 16'sd10 + $urandom_range(20)),
                            16'($urandom_range(400))});
    write_cal(RegPresCalC, 64'(16'(5000 + $urandom_range(1000))));
  endtask

  row_t dir_rows[$];

  initial begin
    row_t rw;
    sample.valid = 1'b0;
    sample.mode = 1'b0;
    sample.raw_reading = '0;
    result.ready = 1'b0;
    cal_t = '0; cal_a = '0; cal_b = '0; cal_c = '0; t_fine = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // after reset: all calibration zero, so pressure sees a zero divisor
    dir_rows = '{
      '{1'b1, 20'h00000, 1'b1, 32'd0, 32'd0, 1'b1},
      '{1'b1, 20'hFFFFF, 1'b1, 32'd0, 32'd0, 1'b1},
      '{1'b0, 20'h00000, 1'b1, 32'd0, 32'd0, 1'b0},
      '{1'b0, 20'hFFFFF, 1'b0, 32'd0, 32'd0, 1'b0}
    };
    send_idle = 29; recv_idle = 57;
    foreach (dir_rows[i]) begin
      rw = dir_rows[i];
      send_word(rw.mode, rw.raw);
      if (rw.known) begin
        void'(results_due.pop_back());
        results_due.push_back('{rw.mode, rw.temp, rw.pres, rw.dz});
      end
    end
    drain();

    set_typical();
    dir_rows = '{
      '{1'b1, 20'h80000, 1'b0, 32'd0, 32'd0, 1'b0},
      '{1'b0, 20'h00000, 1'b0, 32'd0, 32'd0, 1'b0},
      '{1'b0, 20'hFFFFF, 1'b0, 32'd0, 32'd0, 1'b0},
      '{1'b0, 20'h80000, 1'b0, 32'd0, 32'd0, 1'b0},
      '{1'b1, 20'h00000, 1'b0, 32'd0, 32'd0, 1'b0},
      '{1'b1, 20'hFFFFF, 1'b0, 32'd0, 32'd0, 1'b0},
      '{1'b1, 20'h55555, 1'b0, 32'd0, 32'd0, 1'b0},
      '{1'b1, 20'hAAAAA, 1'b0, 32'd0, 32'd0, 1'b0}
    };
    foreach (dir_rows[i]) send_word(dir_rows[i].mode, dir_rows[i].raw);
    drain();

    // extremes of every calibration word
    write_cal(RegTempCal, 48'hFFFF_FFFF_FFFF);
    write_cal(RegPresCalA, 64'hFFFF_FFFF_FFFF_FFFF);
    write_cal(RegPresCalB, 64'hFFFF_FFFF_FFFF_FFFF);
    write_cal(RegPresCalC, 64'h0000_0000_0000_FFFF);
    send_word(1'b0, 20'hFFFFF);
    send_word(1'b1, 20'h00000);
    drain();
    write_cal(RegTempCal, 48'h7FFF_7FFF_0000);
    write_cal(RegPresCalA, 64'h8000_8000_8000_FFFF);
    write_cal(RegPresCalB, 64'h8000_8000_8000_8000);
    write_cal(RegPresCalC, 64'h0000_0000_0000_8000);
    send_word(1'b0, 20'h00000);
    send_word(1'b1, 20'hFFFFF);
    send_word(1'b1, 20'h12345);
    drain();
    write_cal(RegPresCalA, 64'h7FFF_7FFF_7FFF_0001);
    write_cal(RegPresCalB, 64'h7FFF_7FFF_7FFF_7FFF);
    write_cal(RegPresCalC, 64'h0000_0000_0000_7FFF);
    send_word(1'b1, 20'h00001);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 29 : (ph == 1) ? 57 : 0;
      recv_idle = (ph == 0) ? 57 : (ph == 1) ? 29 : 0;
      for (int k = 0; k < 7; k++) begin
        if ($urandom_range(3) == 0) begin
          write_cal(RegTempCal, 64'(rand64() & 64'hFFFF_FFFF_FFFF));
          write_cal(RegPresCalA, rand64());
          write_cal(RegPresCalB, rand64());
          write_cal(RegPresCalC, 64'($urandom()));
        end else begin
          set_typical();
        end
        for (int n = 0; n < 33; n++) begin
          send_word($urandom_range(2) != 0, 20'($urandom()));
        end
        drain();
      end
    end

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> pressure_temperature_compensation_core.f
rtl/ptc_pkg.sv
rtl/ptc_if.sv
rtl/ptc_mul.sv
rtl/ptc_div.sv
rtl/pressure_temperature_compensation_core.sv
rtl/ptc_checker.sv
tb/tb.sv
